// ----- sv/bpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    // Fixed field widths of the request and response payloads.
    localparam int MAX_BEACONS = 15;
    localparam int ID_W        = 4;
    localparam int RSSI_W      = 8;
    localparam int STATES_W    = 2 * MAX_BEACONS;
    localparam int FLAGS_W     = MAX_BEACONS;

    // One history row holds five readings, newest in the low byte.
    localparam int HIST_DEPTH = 5;
    localparam int ROW_W      = HIST_DEPTH * RSSI_W;

    typedef logic signed [RSSI_W-1:0] t_rssi;
    typedef logic [ROW_W-1:0]         t_row;
    typedef logic [1:0]               t_prox;

    localparam t_rssi NO_SIGNAL = t_rssi'(-128);
    localparam t_row  EMPTY_ROW = {HIST_DEPTH{NO_SIGNAL}};

    // Proximity state codes.
    localparam t_prox ST_NOT_FOUND = 2'd0;
    localparam t_prox ST_FOUND     = 2'd1;
    localparam t_prox ST_JUST_LEFT = 2'd2;
    localparam t_prox ST_NEIGHBOUR = 2'd3;

    // Request function codes.
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SMP_WR,
        S_TICK,
        S_DONE
    } t_fsm;

    // Reading k of a history row.
    function automatic t_rssi row_slot(input t_row row, input int k);
        return t_rssi'(row[k*RSSI_W +: RSSI_W]);
    endfunction

    // Rises for two readings, then falls for two (h0<h1<h2>h3>h4).
    function automatic logic hist_peak(input t_row row);
        return (row_slot(row, 0) < row_slot(row, 1)) &&
               (row_slot(row, 1) < row_slot(row, 2)) &&
               (row_slot(row, 2) > row_slot(row, 3)) &&
               (row_slot(row, 3) > row_slot(row, 4));
    endfunction

    // Strictly rising toward older readings.
    function automatic logic hist_falling(input t_row row);
        return (row_slot(row, 0) < row_slot(row, 1)) &&
               (row_slot(row, 1) < row_slot(row, 2)) &&
               (row_slot(row, 2) < row_slot(row, 3)) &&
               (row_slot(row, 3) < row_slot(row, 4));
    endfunction

endpackage

`default_nettype wire

// ----- sv/bpc_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bpc_req_if
    import bpc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [ID_W-1:0]   beacon_id;
    t_rssi             rssi;

    modport source (output valid, func, beacon_id, rssi, input ready);
    modport sink   (input valid, func, beacon_id, rssi, output ready);
endinterface

`default_nettype wire

// ----- sv/bpc_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bpc_rsp_if
    import bpc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATES_W-1:0] states_packed;
    logic [FLAGS_W-1:0]  reset_flags;

    modport source (output valid, states_packed, reset_flags, input ready);
    modport sink   (input valid, states_packed, reset_flags, output ready);
endinterface

`default_nettype wire

// ----- sv/beacon_proximity_classifier.sv -----
// Beacon proximity classifier.
// Requests arrive on i_req: func 0 pushes one signal reading into the history
// of beacon_id (ids at or above NUM_BEACONS change nothing), func 1 runs one
// state-update pass over all beacons in index order. Every request yields one
// response on o_rsp with all proximity states and position-reset flags as
// they stand after the request.
// The histories live in a synchronous memory of one 40-bit row per beacon.
// A sample is a read followed by a write back, then the response is loaded
// (an ignored id skips the read and the write). A pass streams the rows out
// one per cycle and updates one beacon per cycle; each update uses the history
// tests registered from that row's read data, so the single memory read port
// feeds the in-order update chain.
// One request is worked on at a time; the next is accepted in the cycle after
// the previous response is loaded, even if the receiver has not taken it yet.
// A stalled receiver holds the response; a finished request then waits for
// the register to drain. Reset clears all states and flags, marks every
// history row empty (reads as not in range) and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module beacon_proximity_classifier
    import bpc_pkg::*;
#(
    parameter int NUM_BEACONS = 15
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    bpc_req_if.sink      i_req,
    bpc_rsp_if.source    o_rsp
);

    localparam int IDX_W    = $clog2(NUM_BEACONS);
    localparam int CNT_W    = $clog2(NUM_BEACONS + 3);
    localparam int LAST_CNT = NUM_BEACONS + 2;
    localparam int FIRST_UPD = 3;

    // Control state.
    t_fsm               r_fsm, n_fsm;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_any_nb;
    logic [IDX_W-1:0]   r_wr_idx;
    t_rssi              r_wr_rssi;

    // Beacon state and flags.
    t_prox              r_state [NUM_BEACONS];
    logic [NUM_BEACONS-1:0] r_flag;

    // History memory with one valid bit per row.
    t_row               r_hist_mem [NUM_BEACONS];
    logic [NUM_BEACONS-1:0] r_row_vld;
    t_row               r_rd_data;
    logic               r_rd_row_vld;
    logic               r_rd_en_q;
    logic [IDX_W-1:0]   r_rd_idx_q;

    // Per-beacon history tests gathered during a pass.
    logic [NUM_BEACONS-1:0] r_peak;
    logic [NUM_BEACONS-1:0] r_fall;
    logic [NUM_BEACONS-1:0] r_nosig;

    // Output register.
    logic                r_out_vld;
    logic [STATES_W-1:0] r_out_states;
    logic [FLAGS_W-1:0]  r_out_flags;

    // Decoded control.
    logic               w_accept;
    logic               w_in_range;
    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_wr_en;
    logic               w_upd_en;
    logic               w_out_load;
    t_row               w_rd_row;
    t_row               w_wr_row;

    // Update-step signals.
    logic [CNT_W-1:0]   w_pos;
    logic [IDX_W-1:0]   w_idx;
    logic [IDX_W-1:0]   w_lo_idx;
    logic [IDX_W-1:0]   w_hi_idx;
    logic               w_has_lo;
    logic               w_has_hi;
    logic               w_left_lo;
    logic               w_left_hi;
    logic               w_left_nb;
    logic               w_left_fall;
    logic               w_any_nb_now;
    t_prox              w_new_state;
    logic               w_new_flag;
    logic [STATES_W-1:0] w_states;
    logic [FLAGS_W-1:0]  w_flags;

    assign w_in_range = ({1'b0, i_req.beacon_id} < (ID_W + 1)'(NUM_BEACONS));
    assign w_accept   = i_req.valid && i_req.ready;

    // Next-state logic.
    always_comb begin
        n_fsm = r_fsm;
        n_cnt = r_cnt;
        case (r_fsm)
            S_IDLE: begin
                n_cnt = '0;
                if (i_req.valid) begin
                    if (i_req.func == FUNC_TICK) begin
                        n_fsm = S_TICK;
                    end else if (w_in_range) begin
                        n_fsm = S_SMP_WR;
                    end else begin
                        n_fsm = S_DONE;
                    end
                end
            end
            S_SMP_WR: begin
                n_fsm = S_DONE;
            end
            S_TICK: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(LAST_CNT)) begin
                    n_fsm = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // Output and strobe logic.
    always_comb begin
        i_req.ready = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = i_req.beacon_id[IDX_W-1:0];
        w_wr_en     = 1'b0;
        w_upd_en    = 1'b0;
        w_out_load  = 1'b0;
        case (r_fsm)
            S_IDLE: begin
                i_req.ready = 1'b1;
                w_rd_en     = i_req.valid && (i_req.func == FUNC_SAMPLE) && w_in_range;
            end
            S_SMP_WR: begin
                w_wr_en = 1'b1;
            end
            S_TICK: begin
                w_rd_addr = r_cnt[IDX_W-1:0];
                w_rd_en   = (r_cnt < CNT_W'(NUM_BEACONS));
                w_upd_en  = (r_cnt >= CNT_W'(FIRST_UPD));
            end
            S_DONE: begin
                w_out_load = !r_out_vld || o_rsp.ready;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_fsm <= n_fsm;
            r_cnt <= n_cnt;
        end
    end

    // Request capture and the neighbour snapshot taken at the start of a pass.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_wr_idx  <= i_req.beacon_id[IDX_W-1:0];
            r_wr_rssi <= i_req.rssi;
            r_any_nb  <= w_any_nb_now;
        end
    end

    always_comb begin
        w_any_nb_now = 1'b0;
        for (int b = 0; b < NUM_BEACONS; b++) begin
            if (r_state[b] == ST_NEIGHBOUR) begin
                w_any_nb_now = 1'b1;
            end
        end
    end

    // History memory: one read port, one write port.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_hist_mem[w_rd_addr];
        end
        if (w_wr_en) begin
            r_hist_mem[r_wr_idx] <= w_wr_row;
        end
    end

    // Row valid bits; an empty row reads as all not in range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_en_q <= 1'b0;
        end else begin
            r_rd_en_q <= w_rd_en && (r_fsm == S_TICK);
            if (w_wr_en) begin
                r_row_vld[r_wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_row_vld <= r_row_vld[w_rd_addr];
            r_rd_idx_q   <= w_rd_addr;
        end
    end

    assign w_rd_row = r_rd_row_vld ? r_rd_data : EMPTY_ROW;
    assign w_wr_row = {w_rd_row[ROW_W-RSSI_W-1:0], r_wr_rssi};

    // History tests for the row that just came out of the memory.
    always_ff @(posedge i_clk) begin
        if (r_rd_en_q) begin
            r_peak[r_rd_idx_q]  <= hist_peak(w_rd_row);
            r_fall[r_rd_idx_q]  <= hist_falling(w_rd_row);
            r_nosig[r_rd_idx_q] <= (row_slot(w_rd_row, 0) == NO_SIGNAL);
        end
    end

    // Neighbour view of the beacon being updated; the lower one is already new.
    assign w_pos    = r_cnt - CNT_W'(FIRST_UPD);
    assign w_idx    = w_pos[IDX_W-1:0];
    assign w_has_lo = (w_idx != '0);
    assign w_has_hi = (w_idx != IDX_W'(NUM_BEACONS - 1));
    assign w_lo_idx = w_has_lo ? (w_idx - IDX_W'(1)) : w_idx;
    assign w_hi_idx = w_has_hi ? (w_idx + IDX_W'(1)) : w_idx;
    assign w_left_lo = w_has_lo && (r_state[w_lo_idx] == ST_JUST_LEFT);
    assign w_left_hi = w_has_hi && (r_state[w_hi_idx] == ST_JUST_LEFT);
    assign w_left_nb = w_left_lo || w_left_hi;
    assign w_left_fall = (w_left_lo && r_fall[w_lo_idx]) ||
                         (w_left_hi && r_fall[w_hi_idx]);

    // Transition rules for one beacon.
    always_comb begin
        w_new_state = r_state[w_idx];
        w_new_flag  = r_flag[w_idx];
        case (r_state[w_idx])
            ST_NOT_FOUND: begin
                if (!r_nosig[w_idx]) begin
                    w_new_state = ST_FOUND;
                end
            end
            ST_FOUND: begin
                if (!r_any_nb && r_peak[w_idx]) begin
                    w_new_state = ST_JUST_LEFT;
                    w_new_flag  = 1'b1;
                end else if (r_nosig[w_idx]) begin
                    w_new_state = ST_NOT_FOUND;
                end else if (w_left_nb) begin
                    w_new_state = ST_NEIGHBOUR;
                end
            end
            ST_JUST_LEFT: begin
                if (w_left_nb) begin
                    w_new_state = ST_NEIGHBOUR;
                end
                w_new_flag = 1'b0;
            end
            default: begin
                if (r_peak[w_idx]) begin
                    if (w_left_fall) begin
                        w_new_state = ST_JUST_LEFT;
                        w_new_flag  = 1'b1;
                    end
                end else if (!w_left_nb) begin
                    w_new_state = ST_FOUND;
                end
            end
        endcase
    end

    // Beacon state and reset flags, updated in place.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BEACONS; b++) begin
                r_state[b] <= ST_NOT_FOUND;
            end
            r_flag <= '0;
        end else if (w_upd_en) begin
            r_state[w_idx] <= w_new_state;
            r_flag[w_idx]  <= w_new_flag;
        end
    end

    // Pack states and flags; unused beacon positions read as zero.
    always_comb begin
        w_states = '0;
        w_flags  = '0;
        for (int b = 0; b < NUM_BEACONS; b++) begin
            w_states[2*b +: 2] = r_state[b];
            w_flags[b]         = r_flag[b];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_states <= w_states;
            r_out_flags  <= w_flags;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.states_packed = r_out_states;
    assign o_rsp.reset_flags   = r_out_flags;

endmodule

`default_nettype wire

// ----- tb/sv/bpc_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the proximity classifier, keeps its own copy of
// the beacon histories, states and reset flags, and compares every response
// with the snapshot predicted for the oldest outstanding request.
module bpc_checker
    import bpc_pkg::*;
#(
    parameter int NUM_BEACONS = 15
) (
    input  wire i_clk,
    input  wire i_rst_n,
    bpc_req_if  req_mon,
    bpc_rsp_if  rsp_mon,
    output int  o_fail_count,
    output int  o_pending,
    output int  o_checked,
    output int  o_departures,
    output int  o_promotions
);

    // All states and flags as they stand after one request.
    typedef struct packed {
        logic [STATES_W-1:0] states;
        logic [FLAGS_W-1:0]  flags;
    } t_snapshot;

    t_snapshot snap_q[$];

    t_rssi hist      [NUM_BEACONS][HIST_DEPTH];
    t_prox prox      [NUM_BEACONS];
    logic  pos_reset [NUM_BEACONS];

    int n_fail     = 0;
    int n_checked  = 0;
    int n_depart   = 0;
    int n_promote  = 0;

    // Empty histories, every beacon not found, no reset flags.
    task automatic clear_beacons();
        for (int i = 0; i < NUM_BEACONS; i++) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                hist[i][k] = NO_SIGNAL;
            end
            prox[i]      = ST_NOT_FOUND;
            pos_reset[i] = 1'b0;
        end
    endtask

    // Two rises then two falls, newest reading first.
    function automatic logic row_is_peak(input int i);
        return (hist[i][0] < hist[i][1]) && (hist[i][1] < hist[i][2]) &&
               (hist[i][2] > hist[i][3]) && (hist[i][3] > hist[i][4]);
    endfunction

    // Strictly rising toward the older readings: the beacon is receding.
    function automatic logic row_recedes(input int i);
        return (hist[i][0] < hist[i][1]) && (hist[i][1] < hist[i][2]) &&
               (hist[i][2] < hist[i][3]) && (hist[i][3] < hist[i][4]);
    endfunction

    function automatic logic has_left(input int j);
        if (j < 0 || j >= NUM_BEACONS) begin
            return 1'b0;
        end
        return prox[j] == ST_JUST_LEFT;
    endfunction

    function automatic logic near_left(input int i);
        if (i == 0) begin
            return has_left(1);
        end
        if (i == NUM_BEACONS - 1) begin
            return has_left(i - 1);
        end
        return has_left(i - 1) || has_left(i + 1);
    endfunction

    function automatic logic left_receding(input int j);
        return has_left(j) && row_recedes(j);
    endfunction

    // One in-place pass over the beacons; lower neighbours are already updated.
    task automatic update_pass();
        logic any_nb;
        logic go;
        any_nb = 1'b0;
        for (int i = 0; i < NUM_BEACONS; i++) begin
            if (prox[i] == ST_NEIGHBOUR) begin
                any_nb = 1'b1;
            end
        end
        for (int i = 0; i < NUM_BEACONS; i++) begin
            case (prox[i])
                ST_NOT_FOUND: begin
                    if (hist[i][0] != NO_SIGNAL) begin
                        prox[i] = ST_FOUND;
                    end
                end
                ST_FOUND: begin
                    if (!any_nb && row_is_peak(i)) begin
                        prox[i]      = ST_JUST_LEFT;
                        pos_reset[i] = 1'b1;
                        n_depart++;
                    end else if (hist[i][0] == NO_SIGNAL) begin
                        prox[i] = ST_NOT_FOUND;
                    end else if (near_left(i)) begin
                        prox[i] = ST_NEIGHBOUR;
                        n_promote++;
                    end
                end
                ST_JUST_LEFT: begin
                    if (near_left(i)) begin
                        prox[i] = ST_NEIGHBOUR;
                        n_promote++;
                    end
                    pos_reset[i] = 1'b0;
                end
                default: begin
                    if (row_is_peak(i)) begin
                        if (i == NUM_BEACONS - 1) begin
                            go = left_receding(i - 1);
                        end else if (i == 0) begin
                            go = left_receding(1);
                        end else begin
                            go = left_receding(i - 1) || left_receding(i + 1);
                        end
                        if (go) begin
                            prox[i]      = ST_JUST_LEFT;
                            pos_reset[i] = 1'b1;
                            n_depart++;
                        end
                    end else if (!near_left(i)) begin
                        prox[i] = ST_FOUND;
                    end
                end
            endcase
        end
    endtask

    // Applies one request and returns the snapshot the block must answer with.
    task automatic apply_request(input logic func, input logic [ID_W-1:0] id,
                                 input t_rssi rssi, output t_snapshot snap);
        if (func == FUNC_SAMPLE) begin
            if (int'(id) < NUM_BEACONS) begin
                for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                    hist[id][k] = hist[id][k-1];
                end
                hist[id][0] = rssi;
            end
        end else begin
            update_pass();
        end
        snap = '0;
        for (int i = 0; i < NUM_BEACONS; i++) begin
            snap.states[2*i +: 2] = prox[i];
            snap.flags[i]         = pos_reset[i];
        end
    endtask

    // Responses are checked before the request of the same edge is predicted.
    always @(posedge i_clk) begin : monitor
        t_snapshot want;
        t_snapshot got;
        if (!i_rst_n) begin
            clear_beacons();
            snap_q.delete();
        end else begin
            if (rsp_mon.valid && rsp_mon.ready) begin
                got.states = rsp_mon.states_packed;
                got.flags  = rsp_mon.reset_flags;
                if (snap_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected response, expected none, got states %h flags %h",
                             $time, got.states, got.flags);
                end else begin
                    want = snap_q.pop_front();
                    n_checked++;
                    if (got.states !== want.states) begin
                        n_fail++;
                        $display("%0t: states_packed expected %h, got %h",
                                 $time, want.states, got.states);
                    end
                    if (got.flags !== want.flags) begin
                        n_fail++;
                        $display("%0t: reset_flags expected %h, got %h",
                                 $time, want.flags, got.flags);
                    end
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                apply_request(req_mon.func, req_mon.beacon_id, req_mon.rssi, want);
                snap_q.push_back(want);
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= snap_q.size();
        o_checked    <= n_checked;
        o_departures <= n_depart;
        o_promotions <= n_promote;
    end

endmodule

// ----- tb/sv/tb_beacon_proximity_classifier.sv -----
`timescale 1ns / 1ps

// Drives sample and update requests into the classifier, stalls the response
// side at random, and reports the verdict from the checker's failure count.
module tb_beacon_proximity_classifier;
    import bpc_pkg::*;

    localparam int NUM_BEACONS = 15;
    localparam int ITEM_TARGET = 550;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;

    typedef enum int {
        SHAPE_PEAK,
        SHAPE_RECEDE,
        SHAPE_NOISE
    } t_shape;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic steady  = 1'b0;
    int   n_sent  = 0;
    int   n_ticks = 0;

    int fail_count;
    int pending;
    int checked;
    int departures;
    int promotions;

    bpc_req_if req_ch ();
    bpc_rsp_if rsp_ch ();

    beacon_proximity_classifier #(
        .NUM_BEACONS(NUM_BEACONS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    bpc_checker #(
        .NUM_BEACONS(NUM_BEACONS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req_mon     (req_ch),
        .rsp_mon     (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_departures(departures),
        .o_promotions(promotions)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, one long hold-off while the sender keeps going.
    initial begin : sink_side
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && n_sent >= 150) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 99) < 11) begin
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Safety net against a hung handshake.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Offers one request and returns in the step of the edge that accepts it.
    task automatic send_req(input logic func, input int id, input int rssi);
        while (!steady && $urandom_range(0, 99) < 11) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= func;
        req_ch.beacon_id <= id[ID_W-1:0];
        req_ch.rssi      <= t_rssi'(rssi);
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        n_sent++;
        if (func == FUNC_TICK) begin
            n_ticks++;
        end
    endtask

    // An update pass carries random id and rssi bits that the block ignores.
    task automatic send_tick();
        send_req(FUNC_TICK, $urandom_range(0, 15), $urandom_range(0, 255));
    endtask

    // Five readings, oldest first, shaped so the newest-first history matches.
    task automatic push_shape(input int beacon, input t_shape shape);
        int v[HIST_DEPTH];
        int base;
        int step;
        case (shape)
            SHAPE_PEAK: begin
                base = int'($urandom_range(0, 180)) - 104;
                v[0] = base;
                v[1] = v[0] + int'($urandom_range(1, 12));
                v[2] = v[1] + int'($urandom_range(1, 12));
                v[3] = v[2] - int'($urandom_range(1, 12));
                v[4] = v[3] - int'($urandom_range(1, 12));
            end
            SHAPE_RECEDE: begin
                base = int'($urandom_range(0, 207)) - 128;
                step = $urandom_range(1, 12);
                for (int k = 0; k < HIST_DEPTH; k++) begin
                    v[k] = base + (HIST_DEPTH - 1 - k) * step;
                end
            end
            default: begin
                for (int k = 0; k < HIST_DEPTH; k++) begin
                    v[k] = int'($urandom_range(0, 255)) - 128;
                end
            end
        endcase
        for (int k = 0; k < HIST_DEPTH; k++) begin
            send_req(FUNC_SAMPLE, beacon, v[k]);
        end
    endtask

    // Stops offering and waits until every predicted response has come.
    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : source_side
        int   kind;
        int   b;
        logic paused_once;
        paused_once = 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.func      <= FUNC_SAMPLE;
        req_ch.beacon_id <= '0;
        req_ch.rssi      <= NO_SIGNAL;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, an ignored id, found, lost, a departure
        // and the neighbour promotion it triggers.
        send_req(FUNC_SAMPLE, 0, 127);
        send_req(FUNC_SAMPLE, 15, 5);
        send_req(FUNC_SAMPLE, 14, -128);
        send_req(FUNC_SAMPLE, 3, -70);
        send_req(FUNC_SAMPLE, 4, -80);
        send_tick();
        send_req(FUNC_SAMPLE, 3, -50);
        send_req(FUNC_SAMPLE, 3, -30);
        send_req(FUNC_SAMPLE, 3, -40);
        send_req(FUNC_SAMPLE, 3, -60);
        for (int k = 1; k <= HIST_DEPTH; k++) begin
            send_req(FUNC_SAMPLE, 4, -10 * k);
        end
        send_tick();
        send_tick();
        send_req(FUNC_SAMPLE, 14, 127);
        send_tick();
        send_req(FUNC_SAMPLE, 0, -128);
        send_tick();
        wait_drain();

        // Random: mostly shaped histories and departure chains, some noise.
        while (n_sent < ITEM_TARGET) begin
            if (!paused_once && n_sent >= 380) begin
                paused_once = 1'b1;
                wait_drain();
            end
            steady = (n_sent >= 250 && n_sent < 330);
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    push_shape($urandom_range(0, NUM_BEACONS - 1), SHAPE_PEAK);
                    if ($urandom_range(0, 1) == 1) begin
                        send_tick();
                    end
                end
                2: push_shape($urandom_range(0, NUM_BEACONS - 1), SHAPE_RECEDE);
                3: push_shape($urandom_range(0, 15), SHAPE_NOISE);
                4, 5: send_tick();
                6: send_req(FUNC_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 255));
                7: send_req(FUNC_SAMPLE, $urandom_range(0, NUM_BEACONS - 1), -128);
                default: begin
                    // Beacon b departs, b+1 becomes its neighbour, then b+1
                    // departs behind b while b recedes.
                    b = $urandom_range(0, NUM_BEACONS - 2);
                    send_req(FUNC_SAMPLE, b, -90);
                    send_req(FUNC_SAMPLE, b + 1, -95);
                    send_tick();
                    push_shape(b, SHAPE_PEAK);
                    send_tick();
                    push_shape(b, SHAPE_RECEDE);
                    push_shape(b + 1, SHAPE_PEAK);
                    send_tick();
                    send_tick();
                end
            endcase
        end
        steady = 1'b0;

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests (%0d update passes), %0d responses compared.",
                 n_sent, n_ticks, checked);
        $display("Predicted %0d departures and %0d neighbour promotions.",
                 departures, promotions);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
